FILE: design/circle_circle_contact_unit_macros.svh
// Assertion macros for the circle contact unit.
// Used by the top level; no other dependencies.
`ifndef CIRCLE_CIRCLE_CONTACT_UNIT_MACROS_SVH
`define CIRCLE_CIRCLE_CONTACT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ccc_pkg.sv
// Shared constants for the circle contact unit.
// No dependencies; imported by the iterative unit and the top level.
package ccc_pkg;

	// Operation codes of the shared iterative unit.
	localparam logic ITER_DIV  = 1'b0;
	localparam logic ITER_SQRT = 1'b1;

	// Largest radius and depth value.
	localparam logic [30:0] RAD_MAX = 31'h7FFF_FFFF;

endpackage

FILE: design/ccc_mul.sv
// Shared unsigned multiplier with a registered product.
// No dependencies.
module ccc_mul #(
	parameter int W = 36
) (
	input  logic             clk,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [2*W-1:0]   prod
);

	logic [2*W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (2*W)'(a) * (2*W)'(b);
	end

	assign prod = prod_q;

endmodule

FILE: design/ccc_iter.sv
// Bit-serial divider and integer square root sharing one remainder datapath.
// Depends on ccc_pkg for the operation codes.
module ccc_iter #(
	parameter int VW = 36,
	parameter int QW = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            op,
	input  logic [2*VW-1:0] op_a,
	input  logic [VW-1:0]   op_b,
	output logic            busy,
	output logic            done,
	output logic [VW-1:0]   result
);
	import ccc_pkg::*;

	localparam int SW = 2 * VW;
	localparam int NSTEP = (VW > QW) ? VW : QW;
	localparam int CNTW = $clog2(NSTEP + 1);

	logic            busy_q;
	logic            done_q;
	logic            op_q;
	logic            zdiv_q;
	logic [CNTW-1:0] cnt_q;
	logic [VW+1:0]   rem_q;
	logic [SW-1:0]   rad_q;
	logic [VW-1:0]   root_q;
	logic [VW-1:0]   div_q;

	logic [VW+1:0]   sq_rem;
	logic [VW+1:0]   sq_trial;
	logic            sq_ok;
	logic            dv_ok;

	assign sq_rem   = {rem_q[VW-1:0], rad_q[SW-1:SW-2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ok    = sq_rem >= sq_trial;
	assign dv_ok    = rem_q >= {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (op == ITER_SQRT) ? CNTW'(VW) : CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			zdiv_q <= (op_b == '0);
			div_q  <= op_b;
			rad_q  <= op_a;
			root_q <= '0;
			rem_q  <= (op == ITER_SQRT) ? '0 : {2'b00, op_a[VW-1:0]};
		end else if (busy_q) begin
			if (op_q == ITER_SQRT) begin
				rad_q  <= rad_q << 2;
				rem_q  <= sq_ok ? (sq_rem - sq_trial) : sq_rem;
				root_q <= {root_q[VW-2:0], sq_ok};
			end else begin
				rem_q  <= (dv_ok ? (rem_q - {2'b00, div_q}) : rem_q) << 1;
				root_q <= {root_q[VW-2:0], dv_ok};
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = (op_q == ITER_DIV && zdiv_q) ? '0 : root_q;

endmodule

FILE: design/circle_circle_contact_unit.sv
// Circle against circle contact unit: top level, sequencer and datapath.
// Depends on ccc_pkg, ccc_mul, ccc_iter and the assertion macro header.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | consumer  | in_valid/in_stall  | is_second, centers, positions, radius, scale
//   out     | producer  | out_valid/out_stall| hit, point_a/b, normal, depth
//
// Circle A is only stored and gives no result. Circle B runs the bit-serial square root and
// divider of the shared iterative unit on a hit, and goes from the compare straight to the
// output step on a miss.
// The input stalls whenever the sequencer is not idle. Reset clears the stored circle
// and all control state. A stalled result stays in the output register; only the
// final load of a new result waits for it to be taken.
`include "circle_circle_contact_unit_macros.svh"

module circle_circle_contact_unit #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               is_second,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0]        radius,
	input  logic [30:0]        scale_x,
	input  logic [30:0]        scale_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] point_a_x,
	output logic signed [31:0] point_a_y,
	output logic signed [31:0] point_b_x,
	output logic signed [31:0] point_b_y,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic [30:0]        depth
);
	import ccc_pkg::*;

	// Internal vector width: room for coordinates plus offsets and differences.
	localparam int MW = (COORD_BITS > 32) ? COORD_BITS : 32;
	localparam int VW = MW + 4;
	localparam int SW = 2 * VW;
	localparam int QW = FRAC_BITS + 1;

	localparam logic signed [VW-1:0] WMAX = VW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] WMIN = -WMAX - VW'(1);
	localparam logic signed [VW-1:0] P_MAX = VW'(64'sh7FFF_FFFF);
	localparam logic signed [VW-1:0] P_MIN = -P_MAX - VW'(1);
	localparam logic signed [VW-1:0] N_MAX = VW'(64'sh1_FFFF);
	localparam logic signed [VW-1:0] N_MIN = -N_MAX - VW'(1);

	// Sequencer codes.
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RS   = 5'd1;
	localparam logic [4:0] S_RS2  = 5'd2;
	localparam logic [4:0] S_DX   = 5'd3;
	localparam logic [4:0] S_DY   = 5'd4;
	localparam logic [4:0] S_RR   = 5'd5;
	localparam logic [4:0] S_CMP  = 5'd6;
	localparam logic [4:0] S_SQ1  = 5'd7;
	localparam logic [4:0] S_DVX  = 5'd8;
	localparam logic [4:0] S_DVY  = 5'd9;
	localparam logic [4:0] S_OF1  = 5'd10;
	localparam logic [4:0] S_OF2  = 5'd11;
	localparam logic [4:0] S_OF3  = 5'd12;
	localparam logic [4:0] S_OF4  = 5'd13;
	localparam logic [4:0] S_OF5  = 5'd14;
	localparam logic [4:0] S_PT   = 5'd15;
	localparam logic [4:0] S_EX   = 5'd16;
	localparam logic [4:0] S_E1   = 5'd17;
	localparam logic [4:0] S_E2   = 5'd18;
	localparam logic [4:0] S_E3   = 5'd19;
	localparam logic [4:0] S_SQ2  = 5'd20;
	localparam logic [4:0] S_DV3  = 5'd21;
	localparam logic [4:0] S_DV4  = 5'd22;
	localparam logic [4:0] S_OUT  = 5'd23;

	function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
		mag = v[VW-1] ? VW'(-v) : VW'(v);
	endfunction

	function automatic logic signed [VW-1:0] signed_by(input logic neg,
			input logic [VW-1:0] m);
		signed_by = neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [VW-1:0] clamp(input logic signed [VW-1:0] v,
			input logic signed [VW-1:0] lo, input logic signed [VW-1:0] hi);
		if (v > hi)
			clamp = hi;
		else if (v < lo)
			clamp = lo;
		else
			clamp = v;
	endfunction

	logic [4:0] state_q;

	// Stored circle A.
	logic signed [VW-1:0] fwx_q, fwy_q;
	logic [VW-1:0]        frs_q;

	// Current transaction.
	logic                 sec_q;
	logic signed [VW-1:0] wx_q, wy_q;
	logic [30:0]          r_q, smax_q;
	logic [VW-1:0]        rs_q, rsum_q;
	logic signed [VW-1:0] dx_q, dy_q;
	logic [SW-1:0]        acc_q;
	logic [VW-1:0]        len_q;
	logic [VW-1:0]        nxm_q, nym_q;
	logic [VW-1:0]        offax_q, offay_q, offbx_q, offby_q;
	logic signed [VW-1:0] pax_q, pay_q, pbx_q, pby_q;
	logic signed [VW-1:0] ex_q, ey_q;
	logic                 hit_q;

	// Output register.
	logic                 out_valid_q;
	logic                 hit_o;
	logic signed [31:0]   pax_o, pay_o, pbx_o, pby_o;
	logic signed [17:0]   nx_o, ny_o;
	logic [30:0]          depth_o;

	// Shared units.
	logic [VW-1:0]   mul_a, mul_b;
	logic [SW-1:0]   prod;
	logic            it_start, it_op, it_busy, it_done;
	logic [SW-1:0]   it_a;
	logic [VW-1:0]   it_b;
	logic [VW-1:0]   it_res;

	ccc_mul #(.W(VW)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ccc_iter #(.VW(VW), .QW(QW)) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (it_start),
		.op     (it_op),
		.op_a   (it_a),
		.op_b   (it_b),
		.busy   (it_busy),
		.done   (it_done),
		.result (it_res)
	);

	// World center of the incoming circle, saturated to the coordinate range.
	logic signed [VW-1:0] wx_c, wy_c;
	assign wx_c = clamp(VW'(center_x) + VW'(pos_x), WMIN, WMAX);
	assign wy_c = clamp(VW'(center_y) + VW'(pos_y), WMIN, WMAX);

	// Scaled radius from the registered product, saturated.
	logic [SW-1:0] rs_sh;
	logic [VW-1:0] rs_c;
	assign rs_sh = prod >> FRAC_BITS;
	assign rs_c  = (rs_sh > SW'(RAD_MAX)) ? VW'(RAD_MAX) : rs_sh[VW-1:0];

	logic [VW-1:0] off_c;
	assign off_c = prod[FRAC_BITS +: VW];

	logic accept_in, out_free;
	assign accept_in = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// Operand selection for the multiplier and the iterative unit.
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		it_start = 1'b0;
		it_op    = ITER_DIV;
		it_a     = '0;
		it_b     = '0;
		unique case (state_q)
			S_RS: begin
				mul_a = VW'(r_q);
				mul_b = VW'(smax_q);
			end
			S_DX: begin
				mul_a = mag(dx_q);
				mul_b = mag(dx_q);
			end
			S_DY: begin
				mul_a = mag(dy_q);
				mul_b = mag(dy_q);
			end
			S_RR: begin
				mul_a = rsum_q;
				mul_b = rsum_q;
			end
			S_CMP: begin
				it_start = (acc_q <= prod);
				it_op    = ITER_SQRT;
				it_a     = acc_q;
			end
			S_SQ1: begin
				it_start = it_done;
				it_a     = SW'(mag(dx_q));
				it_b     = it_res;
			end
			S_DVX: begin
				it_start = it_done;
				it_a     = SW'(mag(dy_q));
				it_b     = len_q;
			end
			S_OF1: begin
				mul_a = nxm_q;
				mul_b = frs_q;
			end
			S_OF2: begin
				mul_a = nym_q;
				mul_b = frs_q;
			end
			S_OF3: begin
				mul_a = nxm_q;
				mul_b = rs_q;
			end
			S_OF4: begin
				mul_a = nym_q;
				mul_b = rs_q;
			end
			S_E1: begin
				mul_a = mag(ex_q);
				mul_b = mag(ex_q);
			end
			S_E2: begin
				mul_a = mag(ey_q);
				mul_b = mag(ey_q);
			end
			S_E3: begin
				it_start = 1'b1;
				it_op    = ITER_SQRT;
				it_a     = acc_q + prod;
			end
			S_SQ2: begin
				it_start = it_done;
				it_a     = SW'(mag(ex_q));
				it_b     = it_res;
			end
			S_DV3: begin
				it_start = it_done;
				it_a     = SW'(mag(ey_q));
				it_b     = len_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fwx_q   <= '0;
			fwy_q   <= '0;
			frs_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept_in) state_q <= S_RS;
				S_RS:   state_q <= S_RS2;
				S_RS2: begin
					if (!sec_q) begin
						fwx_q   <= wx_q;
						fwy_q   <= wy_q;
						frs_q   <= rs_c;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DX;
					end
				end
				S_DX:  state_q <= S_DY;
				S_DY:  state_q <= S_RR;
				S_RR:  state_q <= S_CMP;
				S_CMP: state_q <= (acc_q > prod) ? S_OUT : S_SQ1;
				S_SQ1: if (it_done) state_q <= S_DVX;
				S_DVX: if (it_done) state_q <= S_DVY;
				S_DVY: if (it_done) state_q <= S_OF1;
				S_OF1: state_q <= S_OF2;
				S_OF2: state_q <= S_OF3;
				S_OF3: state_q <= S_OF4;
				S_OF4: state_q <= S_OF5;
				S_OF5: state_q <= S_PT;
				S_PT:  state_q <= S_EX;
				S_EX:  state_q <= S_E1;
				S_E1:  state_q <= S_E2;
				S_E2:  state_q <= S_E3;
				S_E3:  state_q <= S_SQ2;
				S_SQ2: if (it_done) state_q <= S_DV3;
				S_DV3: if (it_done) state_q <= S_DV4;
				S_DV4: if (it_done) state_q <= S_OUT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					sec_q  <= is_second;
					wx_q   <= wx_c;
					wy_q   <= wy_c;
					r_q    <= radius;
					smax_q <= (scale_x > scale_y) ? scale_x : scale_y;
				end
			end
			S_RS2: begin
				rs_q   <= rs_c;
				rsum_q <= frs_q + rs_c;
				dx_q   <= wx_q - fwx_q;
				dy_q   <= wy_q - fwy_q;
			end
			S_DY:  acc_q <= prod;
			S_RR:  acc_q <= acc_q + prod;
			S_CMP: hit_q <= (acc_q <= prod);
			S_SQ1: if (it_done) len_q <= it_res;
			S_DVX: if (it_done) nxm_q <= it_res;
			S_DVY: if (it_done) nym_q <= it_res;
			S_OF2: offax_q <= off_c;
			S_OF3: offay_q <= off_c;
			S_OF4: offbx_q <= off_c;
			S_OF5: offby_q <= off_c;
			S_PT: begin
				// Offsets follow the sign of the center difference.
				pax_q <= fwx_q + signed_by(dx_q[VW-1], offax_q);
				pay_q <= fwy_q + signed_by(dy_q[VW-1], offay_q);
				pbx_q <= wx_q - signed_by(dx_q[VW-1], offbx_q);
				pby_q <= wy_q - signed_by(dy_q[VW-1], offby_q);
			end
			S_EX: begin
				ex_q <= pbx_q - pax_q;
				ey_q <= pby_q - pay_q;
			end
			S_E2:  acc_q <= prod;
			S_SQ2: if (it_done) len_q <= it_res;
			S_DV3: if (it_done) nxm_q <= it_res;
			S_DV4: if (it_done) nym_q <= it_res;
			default: begin
			end
		endcase
	end

	// Output register; a miss gives all-zero fields.
	logic signed [VW-1:0] nx_full, ny_full;
	assign nx_full = signed_by(ex_q[VW-1], nxm_q);
	assign ny_full = signed_by(ey_q[VW-1], nym_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			hit_o <= hit_q;
			if (hit_q) begin
				pax_o   <= 32'(clamp(pax_q, P_MIN, P_MAX));
				pay_o   <= 32'(clamp(pay_q, P_MIN, P_MAX));
				pbx_o   <= 32'(clamp(pbx_q, P_MIN, P_MAX));
				pby_o   <= 32'(clamp(pby_q, P_MIN, P_MAX));
				nx_o    <= 18'(clamp(nx_full, N_MIN, N_MAX));
				ny_o    <= 18'(clamp(ny_full, N_MIN, N_MAX));
				depth_o <= (len_q > VW'(RAD_MAX)) ? RAD_MAX : len_q[30:0];
			end else begin
				pax_o   <= '0;
				pay_o   <= '0;
				pbx_o   <= '0;
				pby_o   <= '0;
				nx_o    <= '0;
				ny_o    <= '0;
				depth_o <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_o;
	assign point_a_x = pax_o;
	assign point_a_y = pay_o;
	assign point_b_x = pbx_o;
	assign point_b_y = pby_o;
	assign normal_x  = nx_o;
	assign normal_y  = ny_o;
	assign depth     = depth_o;

	// States in which the sequencer waits on the iterative unit.
	logic iter_wait;
	assign iter_wait = (state_q == S_SQ1) || (state_q == S_DVX) || (state_q == S_DVY) ||
		(state_q == S_SQ2) || (state_q == S_DV3) || (state_q == S_DV4);

	// The iterative unit only runs while the sequencer waits on it.
	`CCC_ASSERT_NOW(a_iter_owner, it_busy, iter_wait, "iterative unit busy outside a wait state")

	// A new result appears only after the sequencer's output step.
	`CCC_ASSERT_NOW(a_out_source, $rose(out_valid_q), $past(state_q) == S_OUT, "result raised without output step")

	// A miss carries all-zero fields.
	`CCC_ASSERT_NOW(a_miss_zero, out_valid_q && !hit_o, depth_o == '0 && pax_o == '0 && nx_o == '0, "miss with nonzero fields")

endmodule
